// File: src/mt_pkg.sv
package mt_pkg;

    // Store geometry and twist constants
    localparam int STATE_DEPTH           = 624;
    localparam int TAP_OFFSET            = 397;
    localparam int DEFAULT_WARMUP_ROUNDS = 100;
    localparam int ADDR_W                = $clog2(STATE_DEPTH);
    localparam int WORD_W                = 32;

    localparam logic [WORD_W-1:0] TWIST_XOR = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] TEMPER_B  = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C  = 32'hEFC6_0000;

    // Command codes
    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_SEED = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_WARM_RD,
        S_WARM_WR,
        S_TWIST
    } t_state;

    // Controls from the sequencer to the twist unit
    typedef struct packed {
        logic load_seed;  // fill done: word at position 0 is the seed
        logic step;       // twist the current word, shift in the next one
        logic emit;       // present the tempered word as a result
    } t_twist_ctl;

    // Twist of one word from the words at here, here+1 and the tap
    function automatic logic [WORD_W-1:0] twist_word(
        input logic [WORD_W-1:0] cur,
        input logic [WORD_W-1:0] nxt,
        input logic [WORD_W-1:0] tap
    );
        logic [WORD_W-1:0] mix;
        mix = {cur[WORD_W-1], nxt[WORD_W-2:0]};
        return tap ^ {1'b0, mix[WORD_W-1:1]} ^ (mix[0] ? TWIST_XOR : '0);
    endfunction

    // Output tempering
    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] t;
        t = w ^ (w >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

// File: src/mt_state_ram.sv
module mt_state_ram (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [mt_pkg::ADDR_W-1:0]           i_waddr,
    input  logic [mt_pkg::WORD_W-1:0]           i_wdata,
    input  logic                                i_re,
    input  logic [mt_pkg::ADDR_W-1:0]           i_raddr_a,
    input  logic [mt_pkg::ADDR_W-1:0]           i_raddr_b,
    output logic [mt_pkg::WORD_W-1:0]           o_rdata_a,
    output logic [mt_pkg::WORD_W-1:0]           o_rdata_b
);

    logic [mt_pkg::WORD_W-1:0] r_mem [mt_pkg::STATE_DEPTH];

    // One write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// File: src/mt_twist_unit.sv
module mt_twist_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mt_pkg::t_twist_ctl         i_ctl,
    input  logic [mt_pkg::WORD_W-1:0]  i_seed,
    input  logic [mt_pkg::WORD_W-1:0]  i_next_word,
    input  logic [mt_pkg::WORD_W-1:0]  i_tap_word,
    output logic [mt_pkg::WORD_W-1:0]  o_new_word,
    output logic                       o_valid,
    output logic [mt_pkg::WORD_W-1:0]  o_random_value
);

    // Word at the current position, carried over from the previous read
    logic [mt_pkg::WORD_W-1:0] r_cur;

    assign o_new_word = mt_pkg::twist_word(r_cur, i_next_word, i_tap_word);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_seed) begin
            r_cur <= i_seed;
        end else if (i_ctl.step) begin
            r_cur <= i_next_word;
        end
    end

    // Result register, one cycle strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_random_value <= mt_pkg::temper(o_new_word);
        end
    end

endmodule

// File: src/mt19937_random_generator.sv
// Mersenne twister (MT19937) with a per-word twist, 624-word state store.
// Command port: an item is taken at a clock edge with start high and busy
// low. i_opcode selects a draw or a reseed from i_seed_value.
// Draw: the word at position+1 and the tap word are read from the store at
// the accept edge. The next cycle twists and writes back the word at the
// position. The tempered value is registered in the twist unit and is on
// o_random_value with o_valid high for one cycle. busy is high for one
// cycle, in the twist state, so a new draw can be taken only when that
// state has passed. The word at the position is kept in a register
// from the previous read, so both store ports can serve one draw.
// Reseed: no result. The store is filled with the seed, one word a cycle,
// then 624 * WARMUP_ROUNDS silent draws run, each a read state then a
// write state; busy stays high until the last of them is written.
// Reset: synchronous, active low; clears the position and the sequencer.
// The store keeps no reset value, so draws before the first reseed give
// undefined words. The receiver cannot stall: each result is on the port
// for exactly one cycle.
module mt19937_random_generator #(
    parameter int WARMUP_ROUNDS = mt_pkg::DEFAULT_WARMUP_ROUNDS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_opcode,
    input  logic [mt_pkg::WORD_W-1:0]  i_seed_value,
    output logic                       o_valid,
    output logic [mt_pkg::WORD_W-1:0]  o_random_value
);

    localparam int AW       = mt_pkg::ADDR_W;
    localparam int RND_W    = (WARMUP_ROUNDS < 2) ? 1 : $clog2(WARMUP_ROUNDS + 1);
    localparam logic [AW-1:0] LAST_POS = AW'(mt_pkg::STATE_DEPTH - 1);

    mt_pkg::t_state r_state, n_state;
    logic [AW-1:0]            r_pos, n_pos;
    logic [mt_pkg::WORD_W-1:0] r_seed, n_seed;
    logic [RND_W-1:0]         r_round, n_round;

    logic                      accept;
    logic [AW-1:0]             pos_next;
    logic [AW:0]               tap_sum;
    logic [AW-1:0]             pos_tap;
    logic                      last_round;
    logic                      no_warmup;
    logic                      mem_we;
    logic [mt_pkg::WORD_W-1:0] mem_wdata;
    logic                      mem_re;
    logic [mt_pkg::WORD_W-1:0] next_word, tap_word, new_word;
    mt_pkg::t_twist_ctl        twist_ctl;

    assign accept = start && !busy;

    // Neighbor and tap addresses, modulo the store depth
    assign pos_next = (r_pos == LAST_POS) ? '0 : r_pos + AW'(1);
    assign tap_sum  = {1'b0, r_pos} + (AW+1)'(mt_pkg::TAP_OFFSET);
    assign pos_tap  = (tap_sum >= (AW+1)'(mt_pkg::STATE_DEPTH))
                    ? AW'(tap_sum - (AW+1)'(mt_pkg::STATE_DEPTH))
                    : tap_sum[AW-1:0];

    assign last_round = ({1'b0, r_round} + (RND_W+1)'(1)) == (RND_W+1)'(WARMUP_ROUNDS);
    assign no_warmup  = (WARMUP_ROUNDS == 0);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mt_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = (i_opcode == mt_pkg::OP_SEED) ? mt_pkg::S_FILL
                                                            : mt_pkg::S_TWIST;
                end
            end
            mt_pkg::S_FILL: begin
                if (r_pos == LAST_POS) begin
                    n_state = no_warmup ? mt_pkg::S_IDLE : mt_pkg::S_WARM_RD;
                end
            end
            mt_pkg::S_WARM_RD: n_state = mt_pkg::S_WARM_WR;
            mt_pkg::S_WARM_WR: begin
                n_state = (r_pos == LAST_POS && last_round) ? mt_pkg::S_IDLE
                                                            : mt_pkg::S_WARM_RD;
            end
            mt_pkg::S_TWIST: n_state = mt_pkg::S_IDLE;
            default:         n_state = mt_pkg::S_IDLE;
        endcase
    end

    // Outputs and datapath controls
    always_comb begin
        busy      = 1'b1;
        mem_we    = 1'b0;
        mem_wdata = new_word;
        mem_re    = 1'b0;
        twist_ctl = '0;
        n_pos     = r_pos;
        n_seed    = r_seed;
        n_round   = r_round;
        case (r_state)
            mt_pkg::S_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    if (i_opcode == mt_pkg::OP_SEED) begin
                        n_pos   = '0;
                        n_seed  = i_seed_value;
                        n_round = '0;
                    end else begin
                        mem_re = 1'b1;
                    end
                end
            end
            mt_pkg::S_FILL: begin
                mem_we    = 1'b1;
                mem_wdata = r_seed;
                n_pos     = pos_next;
                twist_ctl.load_seed = (r_pos == LAST_POS);
            end
            mt_pkg::S_WARM_RD: begin
                mem_re = 1'b1;
            end
            mt_pkg::S_WARM_WR: begin
                mem_we         = 1'b1;
                twist_ctl.step = 1'b1;
                n_pos          = pos_next;
                if (r_pos == LAST_POS) begin
                    n_round = r_round + RND_W'(1);
                end
            end
            mt_pkg::S_TWIST: begin
                mem_we         = 1'b1;
                twist_ctl.step = 1'b1;
                twist_ctl.emit = 1'b1;
                n_pos          = pos_next;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mt_pkg::S_IDLE;
            r_pos   <= '0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_round <= n_round;
        end
    end

    always_ff @(posedge i_clk) begin
        r_seed <= n_seed;
    end

    mt_state_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (r_pos),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (pos_next),
        .i_raddr_b (pos_tap),
        .o_rdata_a (next_word),
        .o_rdata_b (tap_word)
    );

    mt_twist_unit u_twist (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (twist_ctl),
        .i_seed         (r_seed),
        .i_next_word    (next_word),
        .i_tap_word     (tap_word),
        .o_new_word     (new_word),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

`ifndef SYNTHESIS
    // A draw taken gives its result: o_valid rises after the twist state
    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_opcode == mt_pkg::OP_DRAW) |=> ##1 o_valid)
        else $error("draw item produced no result");

    // A result only follows a draw twist, never warm-up
    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(r_state) == mt_pkg::S_TWIST))
        else $error("result strobe without a draw");

    // Position stays inside the store
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= LAST_POS)
        else $error("position out of range");

    // Store is never read and written in the same cycle
    a_no_rw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("store read and write overlap");
`endif

endmodule
